@@ hdl/ps2mpt_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package ps2mpt_pkg;

  // Configuration register indexes
  localparam logic [1:0] RegEnabled = 2'd0;
  localparam logic [1:0] RegColumns = 2'd1;
  localparam logic [1:0] RegRows    = 2'd2;

  localparam int          CfgIndexWidth = 2;
  localparam int          CfgDataWidth  = 8;

  localparam logic [7:0] ColumnsReset  = 8'd80;
  localparam logic [7:0] RowsReset     = 8'd25;
  localparam logic [7:0] ColumnReset   = 8'd40;
  localparam logic [7:0] RowReset      = 8'd12;

  localparam logic [7:0] OverflowMask  = 8'hC0;

  localparam int          QueueDepth    = 2;

  // One complete, non-overflow packet handed from front to back
  typedef struct packed {
    logic [2:0] buttons;
    logic [7:0] delta_x;
    logic [7:0] delta_y;
  } packet_t;

  typedef struct packed {
    logic [7:0] columns;
    logic [7:0] rows;
  } screen_cfg_t;

  // Queue status seen by the front and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ hdl/ps2mpt_front.sv @@
// Front end: accepts mouse words, tracks the byte position in a packet and
// pushes complete packets without overflow. Depends on ps2mpt_pkg.
`timescale 1ns / 1ps

module ps2mpt_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      enabled,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data,
  input  ps2mpt_pkg::queue_status_t q_status,
  output logic                      push,
  output ps2mpt_pkg::packet_t       push_packet
);

  logic [1:0] byte_index;
  logic [7:0] flags_byte;
  logic [7:0] delta_x_byte;
  logic       accept;
  logic       take;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  // Drop every word while disabled
  assign take     = accept && enabled;

  assign push = take && (byte_index == 2'd2) &&
                ((flags_byte & ps2mpt_pkg::OverflowMask) == 8'd0);
  assign push_packet.buttons = flags_byte[2:0];
  assign push_packet.delta_x = delta_x_byte;
  assign push_packet.delta_y = in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 2'd0;
    end else if (take) begin
      case (byte_index)
        2'd1: begin
          delta_x_byte <= in_data;
          byte_index   <= 2'd2;
        end
        2'd2: begin
          byte_index <= 2'd0;
        end
        default: begin
          flags_byte <= in_data;
          byte_index <= 2'd1;
        end
      endcase
    end
  end

endmodule

@@ hdl/ps2mpt_queue.sv @@
// Short packet queue between front and back end.
// Depends on ps2mpt_pkg for the packet type.
`timescale 1ns / 1ps

module ps2mpt_queue #(
  parameter int Depth = ps2mpt_pkg::QueueDepth
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  ps2mpt_pkg::packet_t       push_packet,
  input  logic                      pop,
  output ps2mpt_pkg::packet_t       head,
  output ps2mpt_pkg::queue_status_t status
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  ps2mpt_pkg::packet_t entries [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = (count == CW'(Depth));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_packet;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/ps2mpt_back.sv @@
// Back end: applies packet deltas to the cursor, clamps to the screen and
// holds the result word in an output register. Depends on ps2mpt_pkg.
`timescale 1ns / 1ps

module ps2mpt_back (
  input  logic                    clk,
  input  logic                    rst,
  input  ps2mpt_pkg::screen_cfg_t screen,
  input  logic                    q_valid,
  input  ps2mpt_pkg::packet_t     q_packet,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_column,
  output logic [7:0]              out_row,
  output logic [2:0]              out_buttons
);

  logic [7:0]        column_pos;
  logic [7:0]        row_pos;
  logic [7:0]        column_next;
  logic [7:0]        row_next;
  logic signed [9:0] col_sum;
  logic signed [9:0] row_sum;

  function automatic logic [7:0] clamp_coord(input logic signed [9:0] v,
                                             input logic [7:0] size);
    logic [7:0] top;
    top = (size == 8'd0) ? 8'd0 : size - 8'd1;
    if (v[9]) begin
      clamp_coord = 8'd0;
    end else if (v[8:0] > {1'b0, top}) begin
      clamp_coord = top;
    end else begin
      clamp_coord = v[7:0];
    end
  endfunction

  // Take the head when the output register is free or being emptied
  assign pop = q_valid && (!out_valid || out_ready);

  assign col_sum = $signed({2'b00, column_pos}) +
                   $signed({{2{q_packet.delta_x[7]}}, q_packet.delta_x});
  assign row_sum = $signed({2'b00, row_pos}) -
                   $signed({{2{q_packet.delta_y[7]}}, q_packet.delta_y});
  assign column_next = clamp_coord(col_sum, screen.columns);
  assign row_next    = clamp_coord(row_sum, screen.rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= ps2mpt_pkg::ColumnReset;
      row_pos    <= ps2mpt_pkg::RowReset;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        column_pos <= column_next;
        row_pos    <= row_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_column  <= column_next;
      out_row     <= row_next;
      out_buttons <= q_packet.buttons;
    end
  end

endmodule

@@ hdl/ps2_mouse_packet_tracker_unit.sv @@
// Top level of the PS/2 mouse packet tracker: configuration registers,
// front end, packet queue and back end. Depends on ps2mpt_pkg and the ps2mpt_* modules.
`timescale 1ns / 1ps

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata: data_byte[7:0]
//  m_       | out       | m_tvalid/m_tready  | m_tdata: cursor_column, cursor_row, buttons
//  cfg_     | in        | cfg_we (no wait)   | cfg_index selects enabled/columns/rows
//
// One mouse word per cycle is taken while the queue has room; the front end only
// counts bytes, so words stream with no gaps. A packet's third word writes the
// queue as it is taken; the back end then loads the output register from the
// queue head once that register is free or being emptied.
// The back end's single add-and-clamp stage retires a packet per cycle unless stalled.
// Reset (rst, synchronous) disables the block, sets an 80x25 screen, parks the
// cursor at column 40, row 12 and empties the queue.
// A stalled output holds its word; the queue then fills and s_tready drops.

module ps2_mouse_packet_tracker_unit #(
  parameter int QueueDepth = ps2mpt_pkg::QueueDepth
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] data_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [23:0]                         m_tdata,   // [7:0] cursor_column,
                                                         // [15:8] cursor_row,
                                                         // [18:16] button_bits, rest 0
  input  logic                                cfg_we,
  input  logic [ps2mpt_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [ps2mpt_pkg::CfgDataWidth-1:0]  cfg_data
);

  logic                      enabled;
  ps2mpt_pkg::screen_cfg_t   screen;
  ps2mpt_pkg::queue_status_t q_status;
  ps2mpt_pkg::packet_t       push_packet;
  ps2mpt_pkg::packet_t       q_head;
  logic                      q_push;
  logic                      q_pop;
  logic [7:0]                out_column;
  logic [7:0]                out_row;
  logic [2:0]                out_buttons;

  // Configuration registers; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b0;
      screen.columns <= ps2mpt_pkg::ColumnsReset;
      screen.rows    <= ps2mpt_pkg::RowsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        ps2mpt_pkg::RegEnabled: enabled        <= cfg_data[0];
        ps2mpt_pkg::RegColumns: screen.columns <= cfg_data;
        ps2mpt_pkg::RegRows:    screen.rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: count bytes into packets, drop overflow packets
  ps2mpt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .enabled     (enabled),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_data     (s_tdata),
    .q_status    (q_status),
    .push        (q_push),
    .push_packet (push_packet)
  );

  // Queue: decouple byte intake from the cursor update
  ps2mpt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (q_push),
    .push_packet (push_packet),
    .pop         (q_pop),
    .head        (q_head),
    .status      (q_status)
  );

  // Back: move and clamp the cursor, hold the result word
  ps2mpt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .screen      (screen),
    .q_valid     (!q_status.empty),
    .q_packet    (q_head),
    .pop         (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_column  (out_column),
    .out_row     (out_row),
    .out_buttons (out_buttons)
  );

  assign m_tdata = {5'd0, out_buttons, out_row, out_column};

  // Front never pushes into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("packet pushed into full queue");

  // A popped packet lands in the output register
  a_pop_fills_output: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid)
    else $error("popped packet did not reach output");

  // A new result word only follows a pop
  a_output_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(q_pop))
    else $error("result word without a popped packet");

  // Nothing is popped from an empty queue
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

@@ test/ps2_mouse_packet_tracker_unit_test.sv @@
// Self-checking bench for ps2_mouse_packet_tracker_unit: streams mouse words, predicts cursor
// updates and compares each output word. Depends on ps2mpt_pkg and the block's RTL.
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_unit_test;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int LongHold     = 300;  // one long receiver hold-off
  localparam int MaxReports   = 10;

  // Index past the register list; the block must ignore writes to it
  localparam logic [ps2mpt_pkg::CfgIndexWidth-1:0] RegSpare = 2'd3;
  localparam logic [7:0] ButtonMask = 8'h07;

  // Where the tracker stands within a three-word packet
  typedef enum logic [1:0] {
    AwaitFlags  = 2'd0,
    AwaitDeltaX = 2'd1,
    AwaitDeltaY = 2'd2
  } packet_phase_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RxFull       = 2'd0,
    RxRandom     = 2'd1,
    RxSparse     = 2'd2,
    RxSlowToggle = 2'd3
  } rx_pattern_t;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
    logic [2:0] buttons;
  } cursor_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;            // [7:0] cursor_column, [15:8] cursor_row,
                                   // [18:16] button_bits, rest 0
  logic                                cfg_we    = 1'b0;
  logic [ps2mpt_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [ps2mpt_pkg::CfgDataWidth-1:0]  cfg_data  = '0;

  ps2_mouse_packet_tracker_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cursor tracker: a shadow copy of the registers and packet state. Every
  // accepted word runs through it; each completed, non-overflow packet leaves
  // one expected cursor word behind.
  // ---------------------------------------------------------------------------
  logic          shadow_enabled = 1'b0;
  logic [7:0]    shadow_columns = ps2mpt_pkg::ColumnsReset;
  logic [7:0]    shadow_rows    = ps2mpt_pkg::RowsReset;

  packet_phase_t pkt_phase  = AwaitFlags;
  logic [7:0]    flags_word = 8'h00;
  logic [7:0]    dx_word    = 8'h00;
  logic [7:0]    cur_column = ps2mpt_pkg::ColumnReset;
  logic [7:0]    cur_row    = ps2mpt_pkg::RowReset;
  logic [2:0]    cur_buttons = 3'd0;

  cursor_word_t  cursor_expected_q[$];
  int            overflow_drops = 0;

  // Clip a coordinate to [0, extent-1]; a zero extent pins it at 0.
  function automatic logic [7:0] clamp_to_screen(input int coord, input logic [7:0] extent);
    int top;
    top = (extent == 8'd0) ? 0 : int'(extent) - 1;
    if (coord < 0) return 8'd0;
    if (coord > top) return 8'(top);
    return 8'(coord);
  endfunction

  task automatic track_mouse_word(input logic [7:0] word);
    if (!shadow_enabled) return;   // drop the word, keep packet position
    case (pkt_phase)
      AwaitDeltaX: begin
        dx_word   = word;
        pkt_phase = AwaitDeltaY;
      end
      AwaitDeltaY: begin
        pkt_phase = AwaitFlags;
        if ((flags_word & ps2mpt_pkg::OverflowMask) != 8'h00) begin
          overflow_drops++;
        end else begin
          // Sign bits in the flags word are ignored; the deltas carry their own sign
          cur_column  = clamp_to_screen(int'(cur_column) + int'($signed(dx_word)),
                                        shadow_columns);
          cur_row     = clamp_to_screen(int'(cur_row) - int'($signed(word)), shadow_rows);
          cur_buttons = 3'(flags_word & ButtonMask);
          cursor_expected_q.push_back('{column: cur_column, row: cur_row,
                                        buttons: cur_buttons});
        end
      end
      default: begin
        // No sync check on flags bit 3: any word opens a packet
        flags_word = word;
        pkt_phase  = AwaitDeltaX;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps, fed from the backlog.
  // Gaps are suppressed while the receiver is held off so the block fills up.
  // ---------------------------------------------------------------------------
  logic [7:0] mouse_word_q[$];
  int         words_queued   = 0;
  int         words_accepted = 0;
  int         burst_left     = 0;
  int         gap_left       = 0;
  int         hold_left      = 0;
  logic       pressure_arm   = 1'b0;
  logic       pressure_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_mouse_word(s_tdata);
        words_accepted++;
      end
      // Hold the word until it is taken
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0 && hold_left == 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (mouse_word_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= mouse_word_q.pop_front();
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 23);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here; started once when the stimulus arms it
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (pressure_arm && !pressure_done) begin
      hold_left     <= LongHold;
      pressure_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each output word against the oldest expected cursor word
  // and stalls on a pattern picked anew when the low six bits of its tick wrap.
  // ---------------------------------------------------------------------------
  int          mismatches  = 0;
  int          words_checked = 0;
  logic [15:0] rx_tick     = '0;
  rx_pattern_t rx_pattern  = RxFull;

  always @(posedge clk) begin
    cursor_word_t want;
    logic         ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cursor_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("[%0t] unexpected output word %h with nothing pending", $realtime, m_tdata);
        end else begin
          want = cursor_expected_q.pop_front();
          words_checked++;
          if (m_tdata[7:0] !== want.column || m_tdata[15:8] !== want.row ||
              m_tdata[18:16] !== want.buttons || m_tdata[23:19] !== 5'd0) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("[%0t] cursor mismatch: expected col %0d row %0d buttons %b pad 0, got col %0d row %0d buttons %b pad %b",
                       $realtime, want.column, want.row, want.buttons,
                       m_tdata[7:0], m_tdata[15:8], m_tdata[18:16], m_tdata[23:19]);
          end
        end
      end

      rx_tick <= rx_tick + 16'd1;
      if (rx_tick[5:0] == 6'd0) rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      case (rx_pattern)
        RxFull:       ready = 1'b1;
        RxRandom:     ready = ($urandom_range(0, 3) != 0);
        RxSparse:     ready = (rx_tick[2:0] == 3'd0);
        default:      ready = rx_tick[3];
      endcase
      m_tready <= ready && (hold_left == 0);
    end
  end

  // Global watchdog
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_mouse_word(input logic [7:0] word);
    mouse_word_q.push_back(word);
    words_queued++;
  endtask

  task automatic push_mouse_packet(input logic [7:0] flags, input logic [7:0] dx,
                                   input logic [7:0] dy);
    push_mouse_word(flags);
    push_mouse_word(dx);
    push_mouse_word(dy);
  endtask

  // Wait until every queued word is taken and every cursor word has come back,
  // then let the pipeline settle so no dropped packet is still in flight.
  task automatic wait_until_drained();
    do @(posedge clk);
    while (words_accepted != words_queued || cursor_expected_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ps2mpt_pkg::CfgIndexWidth-1:0] idx,
                           input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      ps2mpt_pkg::RegEnabled: shadow_enabled = value[0];
      ps2mpt_pkg::RegColumns: shadow_columns = value;
      ps2mpt_pkg::RegRows:    shadow_rows    = value;
      default: ;
    endcase
  endtask

  // Mostly well-formed packets with random content; the rest is stray words
  // that knock the stream out of alignment.
  task automatic stream_random_traffic(input int count);
    int         pushed;
    logic [7:0] flags;
    logic [7:0] dx;
    logic [7:0] dy;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 99) < 10) begin
        push_mouse_word(8'($urandom_range(0, 255)));
        pushed += 1;
      end else begin
        flags = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0) flags[7:6] = 2'b00;
        if ($urandom_range(0, 2) == 0) begin
          dx = 8'($urandom_range(0, 255));
          dy = 8'($urandom_range(0, 255));
        end else begin
          dx = 8'($urandom_range(0, 31) - 16);
          dy = 8'($urandom_range(0, 31) - 16);
        end
        push_mouse_packet(flags, dx, dy);
        pushed += 3;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Disabled after reset: a whole packet must vanish
    push_mouse_packet(8'h08, 8'h05, 8'h05);
    wait_until_drained();
    write_reg(ps2mpt_pkg::RegEnabled, 8'h01);

    // Directed packets: no motion, full-scale deltas into both corners,
    // overflow drops, sign bits set but ignored, missing sync bit
    push_mouse_packet(8'h08, 8'h00, 8'h00);
    push_mouse_packet(8'h0F, 8'h7F, 8'h80);
    push_mouse_packet(8'h09, 8'h80, 8'h7F);
    push_mouse_packet(8'hC0, 8'h10, 8'h10);
    push_mouse_packet(8'h40, 8'h01, 8'h01);
    push_mouse_packet(8'h3F, 8'h01, 8'hFF);
    push_mouse_packet(8'h00, 8'hFF, 8'h01);
    // Disable in mid-packet: position within the packet must survive
    push_mouse_word(8'h0A);
    push_mouse_word(8'h03);
    wait_until_drained();
    write_reg(ps2mpt_pkg::RegEnabled, 8'h02);   // bit 0 clear: disabled
    push_mouse_word(8'hC0);
    wait_until_drained();
    write_reg(ps2mpt_pkg::RegEnabled, 8'hFF);   // only bit 0 counts
    push_mouse_word(8'hFC);
    wait_until_drained();

    // Default screen; arm the long receiver hold-off while the backlog is deep
    write_reg(ps2mpt_pkg::RegColumns, 8'd80);
    write_reg(ps2mpt_pkg::RegRows, 8'd25);
    stream_random_traffic(320);
    @(posedge clk);
    pressure_arm <= 1'b1;
    wait_until_drained();

    // Largest screen
    write_reg(ps2mpt_pkg::RegColumns, 8'd255);
    write_reg(ps2mpt_pkg::RegRows, 8'd255);
    stream_random_traffic(260);
    wait_until_drained();

    // Shrink: stored position may sit beyond the new bounds until the next packet
    write_reg(ps2mpt_pkg::RegColumns, 8'd12);
    write_reg(ps2mpt_pkg::RegRows, 8'd6);
    stream_random_traffic(100);
    wait_until_drained();

    // Smallest legal screen
    write_reg(ps2mpt_pkg::RegColumns, 8'd1);
    write_reg(ps2mpt_pkg::RegRows, 8'd1);
    stream_random_traffic(100);
    wait_until_drained();

    // Zero-sized screen and a write to the unused index
    write_reg(ps2mpt_pkg::RegColumns, 8'd0);
    write_reg(ps2mpt_pkg::RegRows, 8'd0);
    write_reg(RegSpare, 8'hFF);
    stream_random_traffic(80);
    wait_until_drained();

    // Noise while disabled, then wide and flat
    write_reg(ps2mpt_pkg::RegEnabled, 8'h00);
    stream_random_traffic(20);
    wait_until_drained();
    write_reg(ps2mpt_pkg::RegEnabled, 8'h01);
    write_reg(ps2mpt_pkg::RegColumns, 8'd255);
    write_reg(ps2mpt_pkg::RegRows, 8'd1);
    stream_random_traffic(100);
    wait_until_drained();

    // Narrow and tall
    write_reg(ps2mpt_pkg::RegColumns, 8'd40);
    write_reg(ps2mpt_pkg::RegRows, 8'd200);
    stream_random_traffic(200);
    wait_until_drained();

    $display("Run covered %0d mouse words, %0d cursor words checked, %0d overflow packets dropped.",
             words_accepted, words_checked, overflow_drops);
    $display("Screens 80x25, 255x255, 12x6, 1x1, 0x0, 255x1, 40x200; one %0d-cycle output stall.",
             LongHold);
    if (mismatches == 0 && cursor_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
